### sv/kpsq_pkg.sv
// kpsq_pkg: shared types and codes for the keyed priority send queue.
// No dependencies; imported by the cell, top level and checker.
package kpsq_pkg;

    // One queue entry as held in a cell
    typedef struct packed {
        logic [15:0] prio;
        logic [31:0] serial;
        logic [31:0] ip;
        logic [15:0] port;
        logic [7:0]  count_r;
        logic [7:0]  count_t;
    } t_entry;

    // Per-cycle command broadcast to every cell
    typedef struct packed {
        logic shift_left;   // close the gap left by a removed entry
        logic insert;       // open a slot and place the new entry
    } t_cell_ctl;

    // Action codes
    localparam logic ACT_ADD = 1'b0;
    localparam logic ACT_POP = 1'b1;

    // Status codes
    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_EMPTY = 2'd1;
    localparam logic [1:0] STAT_FULL  = 2'd2;

    // Serial reported by a pop on an empty queue
    localparam logic [31:0] EMPTY_SERIAL = 32'h0000_FFFF;

    localparam int unsigned OCC_W = 7;

endpackage

### sv/kpsq_cell.sv
// kpsq_cell: one slot of the sorted queue, with its key compare and shift mux.
// Depends on kpsq_pkg (t_entry, t_cell_ctl).
module kpsq_cell import kpsq_pkg::*; (
    input  logic      i_clk,
    input  t_cell_ctl i_ctl,
    input  logic      i_occ,          // slot holds a live entry
    input  logic      i_past,         // a removed entry sits at or before this slot
    input  logic      i_prev_before,  // new entry goes before the left neighbor
    input  t_entry    i_new,
    input  t_entry    i_left,
    input  t_entry    i_right,
    output t_entry    o_entry,
    output logic      o_hit,
    output logic      o_before
);

    t_entry r_entry;
    t_entry n_entry;
    logic   served_first;

    // Key match for replace
    assign o_hit = i_occ && (r_entry.serial == i_new.serial);

    // Held entry is served ahead of the new one
    assign served_first = (r_entry.prio > i_new.prio) ||
                          ((r_entry.prio == i_new.prio) && (r_entry.serial < i_new.serial));

    // Empty slots always rank after the new entry, keeping the vector monotone
    assign o_before = !i_occ || !served_first;

    // Shift left on removal, shift right or load on insert
    always_comb begin
        n_entry = r_entry;
        if (i_ctl.shift_left && i_past) begin
            n_entry = i_right;
        end else if (i_ctl.insert && o_before) begin
            n_entry = i_prev_before ? i_left : i_new;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;

endmodule

### sv/kpsq_prefix_or.sv
// kpsq_prefix_or: log-depth inclusive prefix OR across the cell row.
// Standalone; used by the top level to mark cells behind a removed entry.
module kpsq_prefix_or #(
    parameter int unsigned N = 64
) (
    input  logic [N-1:0] i_bits,
    output logic [N-1:0] o_bits
);

    localparam int unsigned LV = (N > 1) ? $clog2(N) : 1;

    logic [N-1:0] lvl [LV+1];

    assign lvl[0] = i_bits;

    // Each level folds in the partner 2**l places to the left
    for (genvar l = 0; l < LV; l++) begin : g_lvl
        for (genvar i = 0; i < N; i++) begin : g_bit
            if (i >= (1 << l)) begin : g_or
                assign lvl[l+1][i] = lvl[l][i] | lvl[l][i-(1 << l)];
            end else begin : g_pass
                assign lvl[l+1][i] = lvl[l][i];
            end
        end
    end

    assign o_bits = lvl[LV];

endmodule

### sv/keyed_priority_send_queue.sv
// keyed_priority_send_queue: top level, a row of kpsq_cell slots kept sorted.
// Depends on kpsq_pkg, kpsq_cell, kpsq_prefix_or.
//
//  channel   | handshake                 | fields
//  ----------+---------------------------+---------------------------------------
//  command   | start, busy               | i_action, i_entry_* (priority .. count_t)
//  result    | o_strobe (one cycle)      | o_status, o_out_*, o_occupancy
//
// Pop: the result strobes the cycle after the beat is taken.
// Add: the beat cycle removes any entry with the same serial,
//   the next cycle (busy high) does the ordered insert; result strobes after it.
// Both phases are one parallel step over the cell row.
// Reset clears the fill count and state; slots need no clearing.
// The receiver cannot stall: each result is shown for exactly one cycle.
module keyed_priority_send_queue import kpsq_pkg::*; #(
    parameter int unsigned CAPACITY = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_action,
    input  logic [15:0] i_entry_priority,
    input  logic [31:0] i_entry_serial,
    input  logic [31:0] i_entry_ip_address,
    input  logic [15:0] i_entry_port,
    input  logic [7:0]  i_entry_count_r,
    input  logic [7:0]  i_entry_count_t,
    output logic        o_strobe,
    output logic [1:0]  o_status,
    output logic [31:0] o_out_serial,
    output logic [31:0] o_out_ip_address,
    output logic [15:0] o_out_port,
    output logic [7:0]  o_out_count_r,
    output logic [7:0]  o_out_count_t,
    output logic [OCC_W-1:0] o_occupancy
);

    localparam int unsigned FW = $clog2(CAPACITY + 1);

    typedef enum logic [1:0] {
        ST_IDLE   = 2'b01,
        ST_INSERT = 2'b10
    } t_state;

    t_state  r_state, n_state;
    logic [FW-1:0] r_fill, n_fill;
    t_entry  r_item;
    t_entry  port_item;
    t_entry  new_item;

    logic        r_strobe, n_strobe;
    logic [1:0]  r_status, n_status;
    t_entry      r_res, n_res;
    logic [OCC_W-1:0] r_occ;

    logic accept, is_pop, empty, full, any_hit, do_insert;
    t_cell_ctl   ctl;

    logic [CAPACITY-1:0] occ, hit, past, prefix_hit, new_ahead;
    t_entry              cell_q [CAPACITY];

    // Command beat fields as one entry
    assign port_item = '{prio: i_entry_priority, serial: i_entry_serial,
                         ip: i_entry_ip_address, port: i_entry_port,
                         count_r: i_entry_count_r, count_t: i_entry_count_t};

    assign busy     = (r_state == ST_INSERT);
    assign accept   = start && !busy;
    assign is_pop   = (i_action == ACT_POP);
    assign empty    = (r_fill == '0);
    assign full     = (r_fill >= FW'(CAPACITY));
    assign new_item = busy ? r_item : port_item;

    // Which cells sit at or behind the entry being removed
    kpsq_prefix_or #(.N(CAPACITY)) u_prefix (
        .i_bits (hit),
        .o_bits (prefix_hit)
    );

    assign any_hit   = prefix_hit[CAPACITY-1];
    assign past      = is_pop ? '1 : prefix_hit;
    assign do_insert = busy && !full;

    assign ctl.shift_left = accept && (is_pop ? !empty : any_hit);
    assign ctl.insert     = do_insert;

    // Row of cells
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        t_entry left_in;
        t_entry right_in;
        logic   prev_before;

        assign occ[g] = (FW'(g) < r_fill);

        if (g == 0) begin : g_first
            assign left_in     = new_item;
            assign prev_before = 1'b0;
        end else begin : g_mid
            assign left_in     = cell_q[g-1];
            assign prev_before = new_ahead[g-1];
        end

        if (g == CAPACITY - 1) begin : g_last
            assign right_in = cell_q[g];
        end else begin : g_inner
            assign right_in = cell_q[g+1];
        end

        kpsq_cell u_cell (
            .i_clk         (i_clk),
            .i_ctl         (ctl),
            .i_occ         (occ[g]),
            .i_past        (past[g]),
            .i_prev_before (prev_before),
            .i_new         (new_item),
            .i_left        (left_in),
            .i_right       (right_in),
            .o_entry       (cell_q[g]),
            .o_hit         (hit[g]),
            .o_before      (new_ahead[g])
        );
    end

    // Sequencing, fill count and result
    always_comb begin
        n_state  = r_state;
        n_fill   = r_fill;
        n_strobe = 1'b0;
        n_status = STAT_OK;
        n_res    = '0;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (is_pop) begin
                        n_strobe = 1'b1;
                        if (empty) begin
                            n_status   = STAT_EMPTY;
                            n_res.serial = EMPTY_SERIAL;
                        end else begin
                            n_res      = cell_q[0];
                            n_res.prio = '0;
                            n_fill     = r_fill - FW'(1);
                        end
                    end else begin
                        if (any_hit) begin
                            n_fill = r_fill - FW'(1);
                        end
                        n_state = ST_INSERT;
                    end
                end
            end
            ST_INSERT: begin
                n_strobe = 1'b1;
                n_state  = ST_IDLE;
                if (full) begin
                    n_status = STAT_FULL;
                end else begin
                    n_fill = r_fill + FW'(1);
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_fill   <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_fill   <= n_fill;
            r_strobe <= n_strobe;
        end
    end

    // Payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (accept && !is_pop) begin
            r_item <= port_item;
        end
        r_status <= n_status;
        r_res    <= n_res;
        r_occ    <= OCC_W'(n_fill);
    end

    assign o_strobe         = r_strobe;
    assign o_status         = r_status;
    assign o_out_serial     = r_res.serial;
    assign o_out_ip_address = r_res.ip;
    assign o_out_port       = r_res.port;
    assign o_out_count_r    = r_res.count_r;
    assign o_out_count_t    = r_res.count_t;
    assign o_occupancy      = r_occ;

endmodule

### sv/kpsq_checker.sv
// kpsq_checker: port-level timing checks for keyed_priority_send_queue, plus bind.
// Depends on kpsq_pkg (action and status codes).
module kpsq_checker import kpsq_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic        i_action,
    input logic        o_strobe,
    input logic [1:0]  o_status,
    input logic [31:0] o_out_serial,
    input logic [OCC_W-1:0] o_occupancy
);

    // An add beat occupies the next cycle and has no result in it
    a_add_two_cycles: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_action == ACT_ADD) |=> (busy && !o_strobe))
        else $error("add beat not followed by insert cycle");

    // A pop beat answers in the very next cycle
    a_pop_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_action == ACT_POP) |=> o_strobe)
        else $error("pop result missing");

    // Insert phase is over by the next cycle, which always reports
    a_busy_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |=> (!busy && o_strobe))
        else $error("insert phase stuck or silent");

    // Empty pop reports the marker serial and an empty queue
    a_empty_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_status == STAT_EMPTY) |-> (o_out_serial == EMPTY_SERIAL &&
                                                 o_occupancy == '0))
        else $error("empty pop result malformed");

endmodule

bind keyed_priority_send_queue kpsq_checker u_kpsq_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .start        (start),
    .busy         (busy),
    .i_action     (i_action),
    .o_strobe     (o_strobe),
    .o_status     (o_status),
    .o_out_serial (o_out_serial),
    .o_occupancy  (o_occupancy)
);

### tb/keyed_priority_send_queue_tb.sv
// keyed_priority_send_queue_tb: self-checking bench for the sorted send queue.
// Mirrors the queue in a sorted list, predicts every reply and checks it on o_strobe.
// Depends on kpsq_pkg and keyed_priority_send_queue.
module keyed_priority_send_queue_tb import kpsq_pkg::*;;

    localparam int unsigned DEPTH       = 64;
    localparam int unsigned MAX_REPORTS = 10;
    localparam int unsigned ITEM_TARGET = 1500;
    localparam int unsigned PHASE_LEN   = 100;
    localparam int unsigned DRAIN_LIMIT = 1000;

    // One reply as it appears on the result ports
    typedef struct packed {
        logic [1:0]       status;
        logic [31:0]      serial;
        logic [31:0]      ip;
        logic [15:0]      port;
        logic [7:0]       count_r;
        logic [7:0]       count_t;
        logic [OCC_W-1:0] occ;
    } t_reply;

    // Sorted shadow of the queue plus the replies still owed by the block
    class queue_order_checker;
        t_entry      held[$];
        t_reply      pending_replies[$];
        int unsigned mismatches = 0;

        function void note_failure(string msg);
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("[%0t] ERROR: %s", $realtime, msg);
        endfunction

        function string show(t_reply r);
            return $sformatf("st=%0d ser=%h ip=%h port=%h cr=%h ct=%h occ=%0d",
                             r.status, r.serial, r.ip, r.port, r.count_r, r.count_t, r.occ);
        endfunction

        // Apply one accepted command beat to the shadow and queue its reply
        function void note_command(logic action, t_entry e);
            t_reply r;
            int     pos;
            r = '0;
            if (action == ACT_POP) begin
                if (held.size() == 0) begin
                    r.status = STAT_EMPTY;
                    r.serial = EMPTY_SERIAL;
                end else begin
                    r.serial  = held[0].serial;
                    r.ip      = held[0].ip;
                    r.port    = held[0].port;
                    r.count_r = held[0].count_r;
                    r.count_t = held[0].count_t;
                    void'(held.pop_front());
                end
            end else begin
                // same serial already held: drop it so the add replaces it
                for (int i = 0; i < held.size(); i++) begin
                    if (held[i].serial == e.serial) begin
                        held.delete(i);
                        break;
                    end
                end
                if (held.size() >= DEPTH) begin
                    r.status = STAT_FULL;
                end else begin
                    // skip entries served first: higher priority, or tie with lower serial
                    pos = 0;
                    while (pos < held.size() && (held[pos].prio > e.prio ||
                           (held[pos].prio == e.prio && held[pos].serial < e.serial)))
                        pos++;
                    held.insert(pos, e);
                end
            end
            r.occ = OCC_W'(held.size());
            pending_replies.push_back(r);
        endfunction

        // Compare a strobed reply with the oldest one owed
        function void check_reply(t_reply got);
            t_reply want;
            string  diff;
            if (pending_replies.size() == 0) begin
                note_failure({"reply with none expected: ", show(got)});
                return;
            end
            want = pending_replies.pop_front();
            diff = "";
            if (got.status  !== want.status)  diff = {diff, " status"};
            if (got.serial  !== want.serial)  diff = {diff, " serial"};
            if (got.ip      !== want.ip)      diff = {diff, " ip"};
            if (got.port    !== want.port)    diff = {diff, " port"};
            if (got.count_r !== want.count_r) diff = {diff, " count_r"};
            if (got.count_t !== want.count_t) diff = {diff, " count_t"};
            if (got.occ     !== want.occ)     diff = {diff, " occupancy"};
            if (diff != "")
                note_failure({"mismatch on", diff, ": expected ", show(want),
                              " got ", show(got)});
        endfunction
    endclass

    logic        i_clk   = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start   = 1'b0;
    logic        busy;
    logic        i_action           = ACT_ADD;
    logic [15:0] i_entry_priority   = '0;
    logic [31:0] i_entry_serial     = '0;
    logic [31:0] i_entry_ip_address = '0;
    logic [15:0] i_entry_port       = '0;
    logic [7:0]  i_entry_count_r    = '0;
    logic [7:0]  i_entry_count_t    = '0;
    logic        o_strobe;
    logic [1:0]  o_status;
    logic [31:0] o_out_serial;
    logic [31:0] o_out_ip_address;
    logic [15:0] o_out_port;
    logic [7:0]  o_out_count_r;
    logic [7:0]  o_out_count_t;
    logic [OCC_W-1:0] o_occupancy;

    queue_order_checker book;

    keyed_priority_send_queue #(.CAPACITY(DEPTH)) dut (.*);

    // 12-unit clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Sample at the rising edge: check the reply first, then log the accepted beat
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_strobe === 1'b1)
                book.check_reply({o_status, o_out_serial, o_out_ip_address, o_out_port,
                                  o_out_count_r, o_out_count_t, o_occupancy});
            if (start && busy === 1'b0)
                book.note_command(i_action, '{prio: i_entry_priority,
                    serial: i_entry_serial, ip: i_entry_ip_address, port: i_entry_port,
                    count_r: i_entry_count_r, count_t: i_entry_count_t});
        end
    end

    // Present one command beat from a falling edge and hold it until taken
    task automatic issue(input logic act, input t_entry e);
        start              <= 1'b1;
        i_action           <= act;
        i_entry_priority   <= e.prio;
        i_entry_serial     <= e.serial;
        i_entry_ip_address <= e.ip;
        i_entry_port       <= e.port;
        i_entry_count_r    <= e.count_r;
        i_entry_count_t    <= e.count_t;
        do @(posedge i_clk); while (busy !== 1'b0);
        @(negedge i_clk);
    endtask

    // Drop start for a number of cycles
    task automatic rest(input int unsigned cycles);
        if (cycles > 0) begin
            start <= 1'b0;
            repeat (cycles) @(negedge i_clk);
        end
    endtask

    function automatic t_entry ent(logic [15:0] prio, logic [31:0] serial, logic [31:0] ip,
                                   logic [15:0] port, logic [7:0] cr, logic [7:0] ct);
        return '{prio: prio, serial: serial, ip: ip, port: port, count_r: cr, count_t: ct};
    endfunction

    // Random entry; half the serials come from a narrow window so replaces happen
    function automatic t_entry random_entry(logic [31:0] window_base);
        t_entry e;
        int unsigned pick;
        pick = $urandom_range(0, 9);
        if (pick < 4)       e.prio = 16'($urandom_range(0, 3));
        else if (pick == 4) e.prio = 16'hFFFF;
        else if (pick == 5) e.prio = 16'h0000;
        else                e.prio = 16'($urandom);
        e.serial  = ($urandom_range(0, 9) < 5) ? window_base + $urandom_range(0, 95)
                                               : $urandom;
        e.ip      = $urandom;
        e.port    = 16'($urandom);
        e.count_r = 8'($urandom);
        e.count_t = 8'($urandom);
        return e;
    endfunction

    // Mostly no gap, sometimes short, rarely long
    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 70) return 0;
        if (roll < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    initial begin
        int unsigned issued;
        int unsigned phase;
        int unsigned pop_pct;
        int unsigned waited;
        bit          quiet;
        logic [31:0] window_base;

        book = new;
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: empty pop, field extremes, replace of the sole entry,
        // tail inserts, priority ties broken by serial, then drain past empty
        issue(ACT_POP, '0);
        issue(ACT_ADD, ent(16'h1234, 32'd5, 32'hFFFF_FFFF, 16'hFFFF, 8'hFF, 8'hFF));
        issue(ACT_ADD, ent(16'h0000, 32'd5, 32'h0, 16'h0, 8'h0, 8'h0));
        issue(ACT_ADD, ent(16'hFFFF, 32'hFFFF_FFFF, 32'hA5A5_5A5A, 16'h5A5A, 8'hA5, 8'h5A));
        issue(ACT_ADD, ent(16'h0000, 32'd0, 32'h0102_0304, 16'd80, 8'd1, 8'd2));
        issue(ACT_ADD, ent(16'h0000, 32'd9, 32'h0A00_0001, 16'd443, 8'd3, 8'd4));
        issue(ACT_ADD, ent(16'h8000, 32'd7, 32'hC0A8_0001, 16'd53, 8'd5, 8'd6));
        issue(ACT_ADD, ent(16'h8000, 32'd3, 32'hC0A8_0002, 16'd54, 8'd7, 8'd8));
        issue(ACT_ADD, ent(16'h7FFF, 32'h8000_0000, 32'h5A5A_A5A5, 16'hA5A5, 8'h5A, 8'hA5));
        repeat (8) issue(ACT_POP, '0);
        issue(ACT_POP, '0);

        // Random phases: fill toward full, drain toward empty, or mixed
        issued = 0;
        phase  = 0;
        while (issued < ITEM_TARGET) begin
            case (phase % 3)
                0:       pop_pct = 10;
                1:       pop_pct = 75;
                default: pop_pct = 45;
            endcase
            quiet       = (phase % 4 == 3);
            window_base = $urandom;
            for (int n = 0; n < PHASE_LEN; n++) begin
                if ($urandom_range(0, 99) < pop_pct)
                    issue(ACT_POP, random_entry(window_base));
                else
                    issue(ACT_ADD, random_entry(window_base));
                if (!quiet)
                    rest(pick_gap());
            end
            issued += PHASE_LEN;
            phase++;
        end
        start <= 1'b0;

        // Wait out the replies still owed, then a few more cycles
        waited = 0;
        while (book.pending_replies.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (8) @(posedge i_clk);
        while (book.pending_replies.size() != 0)
            book.note_failure({"reply never arrived: ",
                               book.show(book.pending_replies.pop_front())});

        if (book.mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #5_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
